@@ rtl/core/bpa_pkg.sv @@
// Package for the buddy page allocator: sizes, status and register codes,
// the page entry layout and the sequencer state type. No dependencies.
package bpa_pkg;

  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SH    = 12;
  localparam int MAX_ORDER  = 10;
  localparam int POOL_PAGES = 65536;

  localparam int ADDR_W  = 48;
  localparam int PB_W    = 29;
  localparam int PG_W    = 16;
  localparam int LNK_W   = 17;
  localparam int ORD_W   = 4;
  localparam int CNT_W   = 17;
  localparam int CIDX_W  = 8;

  localparam logic [LNK_W-1:0] NO_PAGE  = LNK_W'(POOL_PAGES);
  localparam logic [CNT_W-1:0] CNT_MAX  = '1;
  localparam logic [4:0]       UNLISTED = 5'd31;

  localparam logic [CIDX_W-1:0] REG_BASE = 8'd0;
  localparam logic [CIDX_W-1:0] REG_POOL = 8'd1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ORDER_BIG = 3'd1;
  localparam logic [2:0] ST_NO_MEM    = 3'd2;
  localparam logic [2:0] ST_NULL      = 3'd3;
  localparam logic [2:0] ST_OUT_POOL  = 3'd4;
  localparam logic [2:0] ST_MISALIGN  = 3'd5;

  typedef struct packed {
    logic             alloc;
    logic [4:0]       tag;
    logic [LNK_W-1:0] lnk_next;
    logic [LNK_W-1:0] lnk_prev;
  } ent_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_CARVE, S_IDLE, S_CHECK,
    S_A_SPLIT, S_A_MARK_RD, S_A_MARK_WR,
    S_F_CLR_RD, S_F_CLR_WR, S_F_MERGE, S_F_BUD_EV, S_F_STEP, S_F_FIN,
    S_DONE,
    S_U_RD, S_U_EV, S_U_P_RD, S_U_P_WR, S_U_N_RD, S_U_N_WR, S_U_PG_WR,
    S_P_HEAD, S_P_H_RD, S_P_H_WR
  } st_t;

endpackage

@@ rtl/core/bpa_if.sv @@
// Channel interfaces of the buddy page allocator: request, result and
// configuration write. Depends on bpa_pkg for the field widths.
interface bpa_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [4:0]                    block_order;
  logic [bpa_pkg::ADDR_W-1:0]    free_address;
  modport source (output valid, func, block_order, free_address, input ready);
  modport sink   (input valid, func, block_order, free_address, output ready);
endinterface

interface bpa_out_if;
  logic                          valid;
  logic                          ready;
  logic [bpa_pkg::ADDR_W-1:0]    alloc_address;
  logic [2:0]                    status;
  logic [bpa_pkg::CNT_W-1:0]     free_page_total;
  logic [bpa_pkg::CNT_W-1:0]     order_block_count;
  modport source (output valid, alloc_address, status, free_page_total,
                  order_block_count, input ready);
  modport sink   (input valid, alloc_address, status, free_page_total,
                  order_block_count, output ready);
endinterface

interface bpa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bpa_pkg::CIDX_W-1:0]    index;
  logic [bpa_pkg::ADDR_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/buddy_page_allocator.sv @@
// Buddy page allocator top level: sequencer around one page entry memory.
// Depends on bpa_pkg and the channel interfaces in bpa_if.sv.
//
//   channel  | modport | moves
//   ---------+---------+-------------------------------------------------
//   in_ch    | sink    | request: func, block_order, free_address
//   out_ch   | source  | result: alloc_address, status, counts
//   cfg_ch   | sink    | register write: index, data (always ready)
//
// An error found by the check goes straight to the result; an allocate
// unlinks the found block, splits it down to the request and marks it, and
// a free clears the mark, unlinks the page and merges upward with free buddies.
// Each state does at most one page memory access, and read data is registered
// for the state that follows. After reset or a register write the memory is
// cleared, one page a cycle, then the pool is carved into blocks; no request
// is taken meanwhile. A new request is taken while a result waits on out_ch;
// the next result then waits until out_ch.ready.
module buddy_page_allocator (
  input  logic      clk,
  input  logic      rst_n,
  bpa_in_if.sink    in_ch,
  bpa_out_if.source out_ch,
  bpa_cfg_if.sink   cfg_ch
);

  // Page entry memory: alloc mark, listed order and both list links.
  bpa_pkg::ent_t mem [bpa_pkg::POOL_PAGES];
  logic                      mem_we;
  logic [bpa_pkg::PG_W-1:0]  mem_waddr, mem_raddr;
  bpa_pkg::ent_t             mem_wdata, rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  bpa_pkg::st_t st_r, st_nxt, ret_r, ret_nxt;
  logic                        sub_push_r, sub_push_nxt;
  logic [bpa_pkg::PG_W-1:0]    pg_r, pg_nxt;
  logic [bpa_pkg::ORD_W-1:0]   so_r, so_nxt;
  logic                        e_alloc_r, e_alloc_nxt;
  logic [4:0]                  e_tag_r, e_tag_nxt;
  logic [bpa_pkg::LNK_W-1:0]   e_next_r, e_next_nxt, e_prev_r, e_prev_nxt;
  logic [bpa_pkg::LNK_W-1:0]   h_r, h_nxt;
  logic                        func_r, func_nxt;
  logic [4:0]                  ord_r, ord_nxt;
  logic [bpa_pkg::ADDR_W-1:0]  addr_r, addr_nxt;
  logic [bpa_pkg::ORD_W-1:0]   c_r, c_nxt;
  logic [bpa_pkg::PG_W-1:0]    blk_r, blk_nxt, cur_r, cur_nxt, bud_r, bud_nxt;
  logic [2:0]                  stat_r, stat_nxt;
  logic [bpa_pkg::ADDR_W-1:0]  res_r, res_nxt;
  logic [bpa_pkg::LNK_W-1:0]   idx_r, idx_nxt, rem_r, rem_nxt;
  logic [bpa_pkg::ADDR_W-1:0]  base_r, base_nxt;
  logic [bpa_pkg::PB_W-1:0]    pool_r, pool_nxt;
  logic [bpa_pkg::LNK_W-1:0]   head_r [bpa_pkg::MAX_ORDER+1];
  logic [bpa_pkg::LNK_W-1:0]   head_nxt [bpa_pkg::MAX_ORDER+1];
  logic [bpa_pkg::CNT_W-1:0]   cnt_r [bpa_pkg::MAX_ORDER+1];
  logic [bpa_pkg::CNT_W-1:0]   cnt_nxt [bpa_pkg::MAX_ORDER+1];
  logic [bpa_pkg::CNT_W-1:0]   free_r, free_nxt;

  logic                        ov_r, ov_nxt;
  logic [bpa_pkg::ADDR_W-1:0]  o_addr_r, o_addr_nxt;
  logic [2:0]                  o_stat_r, o_stat_nxt;
  logic [bpa_pkg::CNT_W-1:0]   o_free_r, o_free_nxt, o_cnt_r, o_cnt_nxt;

  // Pool page count: byte size rounded up to pages, capped at the memory depth.
  logic [bpa_pkg::PB_W:0]      pp_raw;
  logic [bpa_pkg::LNK_W-1:0]   ppg;
  assign pp_raw = ({1'b0, pool_r} + (bpa_pkg::PB_W+1)'(bpa_pkg::PAGE_BYTES - 1))
                  >> bpa_pkg::PAGE_SH;
  assign ppg = (pp_raw > (bpa_pkg::PB_W+1)'(bpa_pkg::POOL_PAGES)) ? bpa_pkg::NO_PAGE
             : bpa_pkg::LNK_W'(pp_raw);

  // One read port each on the head and count arrays, selected by state.
  logic [bpa_pkg::ORD_W-1:0]   hsel, csel;
  logic [bpa_pkg::LNK_W-1:0]   head_rd;
  logic [bpa_pkg::CNT_W-1:0]   cnt_rd;
  assign head_rd = head_r[hsel];
  assign cnt_rd  = cnt_r[csel];

  logic                        cfg_hit;
  assign cfg_hit = cfg_ch.valid && cfg_ch.ready &&
                   (cfg_ch.index == bpa_pkg::REG_BASE || cfg_ch.index == bpa_pkg::REG_POOL);

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (st_r == bpa_pkg::S_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.alloc_address     = o_addr_r;
  assign out_ch.status            = o_stat_r;
  assign out_ch.free_page_total   = o_free_r;
  assign out_ch.order_block_count = o_cnt_r;

  // Request checks and derived quantities for free, allocate and carving.
  logic [bpa_pkg::ADDR_W-1:0]  diff;
  logic                        f_below, f_oor;
  logic [bpa_pkg::ORD_W-1:0]   found_c;
  logic                        found;
  logic [bpa_pkg::ORD_W-1:0]   carve_o;
  logic [bpa_pkg::PG_W-1:0]    bud_c;
  logic [bpa_pkg::CNT_W:0]     fsum;
  logic [bpa_pkg::CNT_W-1:0]   fstep;

  assign diff    = addr_r - base_r;
  assign f_below = addr_r < base_r;
  assign f_oor   = f_below || (diff >= bpa_pkg::ADDR_W'(pool_r)) ||
                   (diff[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SH] >=
                    (bpa_pkg::ADDR_W-bpa_pkg::PAGE_SH)'(ppg));
  assign bud_c   = cur_r ^ (bpa_pkg::PG_W'(1) << c_r);
  assign fstep   = bpa_pkg::CNT_W'(1) << ord_r[bpa_pkg::ORD_W-1:0];
  assign fsum    = {1'b0, free_r} + {1'b0, fstep};

  always_comb begin
    found   = 1'b0;
    found_c = '0;
    for (int i = bpa_pkg::MAX_ORDER; i >= 0; i--) begin
      if (5'(i) >= ord_r && !head_r[i][bpa_pkg::LNK_W-1]) begin
        found   = 1'b1;
        found_c = bpa_pkg::ORD_W'(i);
      end
    end
  end

  always_comb begin
    carve_o = '0;
    for (int i = 1; i <= bpa_pkg::MAX_ORDER; i++) begin
      if ((bpa_pkg::LNK_W'(1) << i) <= rem_r &&
          (idx_r & ((bpa_pkg::LNK_W'(1) << i) - bpa_pkg::LNK_W'(1))) == '0) begin
        carve_o = bpa_pkg::ORD_W'(i);
      end
    end
  end

  always_comb begin
    st_nxt = st_r;          ret_nxt = ret_r;       sub_push_nxt = sub_push_r;
    pg_nxt = pg_r;          so_nxt = so_r;
    e_alloc_nxt = e_alloc_r; e_tag_nxt = e_tag_r;
    e_next_nxt = e_next_r;  e_prev_nxt = e_prev_r; h_nxt = h_r;
    func_nxt = func_r;      ord_nxt = ord_r;       addr_nxt = addr_r;
    c_nxt = c_r;            blk_nxt = blk_r;       cur_nxt = cur_r;
    bud_nxt = bud_r;        stat_nxt = stat_r;     res_nxt = res_r;
    idx_nxt = idx_r;        rem_nxt = rem_r;
    base_nxt = base_r;      pool_nxt = pool_r;     free_nxt = free_r;
    head_nxt = head_r;      cnt_nxt = cnt_r;
    ov_nxt = ov_r;          o_addr_nxt = o_addr_r; o_stat_nxt = o_stat_r;
    o_free_nxt = o_free_r;  o_cnt_nxt = o_cnt_r;
    mem_we = 1'b0;          mem_waddr = pg_r;      mem_wdata = rdata_r;
    mem_raddr = pg_r;       hsel = so_r;           csel = e_tag_r[bpa_pkg::ORD_W-1:0];

    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    case (st_r)
      bpa_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[bpa_pkg::PG_W-1:0];
        mem_wdata = '{alloc: 1'b0, tag: bpa_pkg::UNLISTED, lnk_next: '0, lnk_prev: '0};
        idx_nxt   = idx_r + 1'b1;
        if (idx_r == bpa_pkg::NO_PAGE - 1'b1) begin
          idx_nxt  = '0;
          rem_nxt  = ppg;
          free_nxt = ppg;
          for (int i = 0; i <= bpa_pkg::MAX_ORDER; i++) begin
            head_nxt[i] = bpa_pkg::NO_PAGE;
            cnt_nxt[i]  = '0;
          end
          st_nxt = bpa_pkg::S_CARVE;
        end
      end
      bpa_pkg::S_CARVE: begin
        if (rem_r == '0) begin
          st_nxt = bpa_pkg::S_IDLE;
        end else begin
          pg_nxt       = idx_r[bpa_pkg::PG_W-1:0];
          so_nxt       = carve_o;
          sub_push_nxt = 1'b1;
          ret_nxt      = bpa_pkg::S_CARVE;
          idx_nxt      = idx_r + (bpa_pkg::LNK_W'(1) << carve_o);
          rem_nxt      = rem_r - (bpa_pkg::LNK_W'(1) << carve_o);
          st_nxt       = bpa_pkg::S_U_RD;
        end
      end
      bpa_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          func_nxt = in_ch.func;
          ord_nxt  = in_ch.block_order;
          addr_nxt = in_ch.free_address;
          st_nxt   = bpa_pkg::S_CHECK;
        end
      end
      bpa_pkg::S_CHECK: begin
        stat_nxt = bpa_pkg::ST_OK;
        res_nxt  = '0;
        c_nxt    = ord_r[bpa_pkg::ORD_W-1:0];
        hsel     = found_c;
        if (ord_r > 5'(bpa_pkg::MAX_ORDER)) begin
          stat_nxt = bpa_pkg::ST_ORDER_BIG;
          st_nxt   = bpa_pkg::S_DONE;
        end else if (!func_r) begin
          if (!found) begin
            stat_nxt = bpa_pkg::ST_NO_MEM;
            st_nxt   = bpa_pkg::S_DONE;
          end else begin
            c_nxt        = found_c;
            blk_nxt      = head_rd[bpa_pkg::PG_W-1:0];
            pg_nxt       = head_rd[bpa_pkg::PG_W-1:0];
            sub_push_nxt = 1'b0;
            ret_nxt      = bpa_pkg::S_A_SPLIT;
            st_nxt       = bpa_pkg::S_U_RD;
          end
        end else if (addr_r == '0) begin
          stat_nxt = bpa_pkg::ST_NULL;
          st_nxt   = bpa_pkg::S_DONE;
        end else if (f_oor) begin
          stat_nxt = bpa_pkg::ST_OUT_POOL;
          st_nxt   = bpa_pkg::S_DONE;
        end else if (addr_r[bpa_pkg::PAGE_SH-1:0] != '0) begin
          stat_nxt = bpa_pkg::ST_MISALIGN;
          st_nxt   = bpa_pkg::S_DONE;
        end else begin
          cur_nxt = diff[bpa_pkg::PAGE_SH+bpa_pkg::PG_W-1:bpa_pkg::PAGE_SH];
          st_nxt  = bpa_pkg::S_F_CLR_RD;
        end
      end
      // Allocate: push each upper half while splitting down to the request.
      bpa_pkg::S_A_SPLIT: begin
        if (5'(c_r) > ord_r) begin
          c_nxt        = c_r - 1'b1;
          pg_nxt       = blk_r + (bpa_pkg::PG_W'(1) << (c_r - 1'b1));
          so_nxt       = c_r - 1'b1;
          sub_push_nxt = 1'b1;
          ret_nxt      = bpa_pkg::S_A_SPLIT;
          st_nxt       = bpa_pkg::S_U_RD;
        end else begin
          st_nxt = bpa_pkg::S_A_MARK_RD;
        end
      end
      bpa_pkg::S_A_MARK_RD: begin
        mem_raddr = blk_r;
        st_nxt    = bpa_pkg::S_A_MARK_WR;
      end
      bpa_pkg::S_A_MARK_WR: begin
        mem_we          = 1'b1;
        mem_waddr       = blk_r;
        mem_wdata.alloc = 1'b1;
        free_nxt        = (free_r > fstep) ? free_r - fstep : '0;
        res_nxt         = base_r + (bpa_pkg::ADDR_W'(blk_r) << bpa_pkg::PAGE_SH);
        st_nxt          = bpa_pkg::S_DONE;
      end
      // Free: clear the mark, unlink, then merge upward.
      bpa_pkg::S_F_CLR_RD: begin
        mem_raddr = cur_r;
        st_nxt    = bpa_pkg::S_F_CLR_WR;
      end
      bpa_pkg::S_F_CLR_WR: begin
        mem_we          = 1'b1;
        mem_waddr       = cur_r;
        mem_wdata.alloc = 1'b0;
        pg_nxt          = cur_r;
        sub_push_nxt    = 1'b0;
        ret_nxt         = bpa_pkg::S_F_MERGE;
        st_nxt          = bpa_pkg::S_U_RD;
      end
      bpa_pkg::S_F_MERGE: begin
        bud_nxt   = bud_c;
        mem_raddr = bud_c;
        if (c_r < bpa_pkg::ORD_W'(bpa_pkg::MAX_ORDER) &&
            bpa_pkg::LNK_W'(bud_c) < ppg) begin
          st_nxt = bpa_pkg::S_F_BUD_EV;
        end else begin
          pg_nxt       = cur_r;
          so_nxt       = c_r;
          sub_push_nxt = 1'b1;
          ret_nxt      = bpa_pkg::S_F_FIN;
          st_nxt       = bpa_pkg::S_U_RD;
        end
      end
      bpa_pkg::S_F_BUD_EV: begin
        pg_nxt = (!rdata_r.alloc && rdata_r.tag == 5'(c_r)) ? bud_r : cur_r;
        if (!rdata_r.alloc && rdata_r.tag == 5'(c_r)) begin
          sub_push_nxt = 1'b0;
          ret_nxt      = bpa_pkg::S_F_STEP;
        end else begin
          so_nxt       = c_r;
          sub_push_nxt = 1'b1;
          ret_nxt      = bpa_pkg::S_F_FIN;
        end
        st_nxt = bpa_pkg::S_U_RD;
      end
      bpa_pkg::S_F_STEP: begin
        if (bud_r < cur_r) begin
          cur_nxt = bud_r;
        end
        c_nxt  = c_r + 1'b1;
        st_nxt = bpa_pkg::S_F_MERGE;
      end
      bpa_pkg::S_F_FIN: begin
        free_nxt = (fsum > {1'b0, bpa_pkg::CNT_MAX}) ? bpa_pkg::CNT_MAX
                 : fsum[bpa_pkg::CNT_W-1:0];
        st_nxt   = bpa_pkg::S_DONE;
      end
      bpa_pkg::S_DONE: begin
        csel = ord_r[bpa_pkg::ORD_W-1:0];
        if (!ov_r || out_ch.ready) begin
          ov_nxt     = 1'b1;
          o_addr_nxt = res_r;
          o_stat_nxt = stat_r;
          o_free_nxt = free_r;
          o_cnt_nxt  = (ord_r > 5'(bpa_pkg::MAX_ORDER)) ? '0 : cnt_rd;
          st_nxt     = bpa_pkg::S_IDLE;
        end
      end
      // Unlink subroutine: page pg_r, then optionally push it at order so_r.
      bpa_pkg::S_U_RD: begin
        mem_raddr = pg_r;
        st_nxt    = bpa_pkg::S_U_EV;
      end
      bpa_pkg::S_U_EV: begin
        e_alloc_nxt = rdata_r.alloc;
        e_tag_nxt   = rdata_r.tag;
        e_next_nxt  = rdata_r.lnk_next;
        e_prev_nxt  = rdata_r.lnk_prev;
        hsel        = rdata_r.tag[bpa_pkg::ORD_W-1:0];
        if (rdata_r.tag > 5'(bpa_pkg::MAX_ORDER)) begin
          st_nxt = sub_push_r ? bpa_pkg::S_P_HEAD : ret_r;
        end else if (!rdata_r.lnk_prev[bpa_pkg::LNK_W-1]) begin
          st_nxt = bpa_pkg::S_U_P_RD;
        end else begin
          head_nxt[rdata_r.tag[bpa_pkg::ORD_W-1:0]] = rdata_r.lnk_next;
          st_nxt = rdata_r.lnk_next[bpa_pkg::LNK_W-1] ? bpa_pkg::S_U_PG_WR
                 : bpa_pkg::S_U_N_RD;
        end
      end
      bpa_pkg::S_U_P_RD: begin
        mem_raddr = e_prev_r[bpa_pkg::PG_W-1:0];
        st_nxt    = bpa_pkg::S_U_P_WR;
      end
      bpa_pkg::S_U_P_WR: begin
        mem_we             = 1'b1;
        mem_waddr          = e_prev_r[bpa_pkg::PG_W-1:0];
        mem_wdata.lnk_next = e_next_r;
        st_nxt = e_next_r[bpa_pkg::LNK_W-1] ? bpa_pkg::S_U_PG_WR : bpa_pkg::S_U_N_RD;
      end
      bpa_pkg::S_U_N_RD: begin
        mem_raddr = e_next_r[bpa_pkg::PG_W-1:0];
        st_nxt    = bpa_pkg::S_U_N_WR;
      end
      bpa_pkg::S_U_N_WR: begin
        mem_we             = 1'b1;
        mem_waddr          = e_next_r[bpa_pkg::PG_W-1:0];
        mem_wdata.lnk_prev = e_prev_r;
        st_nxt             = bpa_pkg::S_U_PG_WR;
      end
      bpa_pkg::S_U_PG_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pg_r;
        mem_wdata = '{alloc: e_alloc_r, tag: bpa_pkg::UNLISTED,
                      lnk_next: e_next_r, lnk_prev: e_prev_r};
        csel      = e_tag_r[bpa_pkg::ORD_W-1:0];
        cnt_nxt[e_tag_r[bpa_pkg::ORD_W-1:0]] = (cnt_rd != '0) ? cnt_rd - 1'b1 : '0;
        st_nxt    = sub_push_r ? bpa_pkg::S_P_HEAD : ret_r;
      end
      bpa_pkg::S_P_HEAD: begin
        hsel      = so_r;
        csel      = so_r;
        mem_we    = 1'b1;
        mem_waddr = pg_r;
        mem_wdata = '{alloc: e_alloc_r, tag: 5'(so_r),
                      lnk_next: head_rd, lnk_prev: bpa_pkg::NO_PAGE};
        head_nxt[so_r] = bpa_pkg::LNK_W'(pg_r);
        cnt_nxt[so_r]  = (cnt_rd != bpa_pkg::CNT_MAX) ? cnt_rd + 1'b1 : cnt_rd;
        h_nxt          = head_rd;
        st_nxt = head_rd[bpa_pkg::LNK_W-1] ? ret_r : bpa_pkg::S_P_H_RD;
      end
      bpa_pkg::S_P_H_RD: begin
        mem_raddr = h_r[bpa_pkg::PG_W-1:0];
        st_nxt    = bpa_pkg::S_P_H_WR;
      end
      bpa_pkg::S_P_H_WR: begin
        mem_we             = 1'b1;
        mem_waddr          = h_r[bpa_pkg::PG_W-1:0];
        mem_wdata.lnk_prev = bpa_pkg::LNK_W'(pg_r);
        st_nxt             = ret_r;
      end
      default: begin
        st_nxt = bpa_pkg::S_CLEAR;
      end
    endcase

    // A register write restarts the clearing pass and the carving.
    if (cfg_hit) begin
      if (cfg_ch.index == bpa_pkg::REG_BASE) begin
        base_nxt = cfg_ch.data;
      end else begin
        pool_nxt = cfg_ch.data[bpa_pkg::PB_W-1:0];
      end
      idx_nxt = '0;
      st_nxt  = bpa_pkg::S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= bpa_pkg::S_CLEAR;
      idx_r  <= '0;
      base_r <= '0;
      pool_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      idx_r  <= idx_nxt;
      base_r <= base_nxt;
      pool_r <= pool_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r <= ret_nxt;       sub_push_r <= sub_push_nxt;
    pg_r <= pg_nxt;         so_r <= so_nxt;
    e_alloc_r <= e_alloc_nxt; e_tag_r <= e_tag_nxt;
    e_next_r <= e_next_nxt; e_prev_r <= e_prev_nxt; h_r <= h_nxt;
    func_r <= func_nxt;     ord_r <= ord_nxt;       addr_r <= addr_nxt;
    c_r <= c_nxt;           blk_r <= blk_nxt;       cur_r <= cur_nxt;
    bud_r <= bud_nxt;       stat_r <= stat_nxt;     res_r <= res_nxt;
    rem_r <= rem_nxt;       free_r <= free_nxt;
    head_r <= head_nxt;     cnt_r <= cnt_nxt;
    o_addr_r <= o_addr_nxt; o_stat_r <= o_stat_nxt;
    o_free_r <= o_free_nxt; o_cnt_r <= o_cnt_nxt;
  end

  // A write of the base or pool register always sends the block back to the clearing pass.
  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> st_r == bpa_pkg::S_CLEAR)
    else $error("register write did not restart the clearing pass");

  // The page memory is never written while waiting for a request.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == bpa_pkg::S_IDLE |-> !mem_we)
    else $error("page memory written while idle");

  // A new result only appears out of the result state.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(st_r) == bpa_pkg::S_DONE)
    else $error("result raised outside the result state");

endmodule

@@ tb/buddy_page_allocator_test.sv @@
// Self-checking testbench for the buddy page allocator: random and directed
// allocate/free requests, checked against an in-bench predictor.
// Depends on bpa_pkg, the channel interfaces in bpa_if.sv and the RTL top.
module buddy_page_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bpa_pkg::*;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;
  localparam logic [CIDX_W-1:0] REG_UNUSED = 8'hA5;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam longint unsigned SAT_TOP = 131071;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [2:0]        status;
    logic [CNT_W-1:0]  page_total;
    logic [CNT_W-1:0]  order_blocks;
  } alloc_result_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [4:0]        order;
  } live_block_t;

  // Scoreboard: keeps a private copy of the allocator state, predicts the
  // result of every accepted request and compares results in order.
  class alloc_scoreboard;
    logic [ADDR_W-1:0] base;
    logic [PB_W-1:0]   pool_b;
    int unsigned       npages;
    bit                marked [POOL_PAGES];
    bit [4:0]          tag [POOL_PAGES];
    int unsigned       nxt [POOL_PAGES];
    int unsigned       prv [POOL_PAGES];
    int unsigned       head [MAX_ORDER+1];
    int unsigned       cnt [MAX_ORDER+1];
    int unsigned       free_left;
    alloc_result_t     pending_results [$];
    live_block_t       live [$];
    int                errors;
    int                checked;
    int                n_alloc_ok;
    int                n_free_ok;
    int                n_error_status;

    function int unsigned sat_add(int unsigned a, int unsigned b);
      longint unsigned s;
      s = longint'(a) + b;
      return (s > SAT_TOP) ? int'(SAT_TOP) : int'(s);
    endfunction

    function int unsigned sat_sub(int unsigned a, int unsigned b);
      return (a > b) ? a - b : 0;
    endfunction

    function void unlink(int unsigned pg);
      int unsigned o, p, n;
      if (pg >= POOL_PAGES) return;
      o = tag[pg];
      if (o > MAX_ORDER) return;
      p = prv[pg];
      n = nxt[pg];
      if (p < POOL_PAGES) nxt[p] = n;
      else head[o] = n;
      if (n < POOL_PAGES) prv[n] = p;
      tag[pg] = UNLISTED;
      cnt[o] = sat_sub(cnt[o], 1);
    endfunction

    function void push(int unsigned pg, int unsigned o);
      int unsigned h;
      if (pg >= POOL_PAGES || o > MAX_ORDER) return;
      unlink(pg);
      h = head[o];
      nxt[pg] = h;
      prv[pg] = POOL_PAGES;
      if (h < POOL_PAGES) prv[h] = pg;
      head[o] = pg;
      tag[pg] = 5'(o);
      cnt[o] = sat_add(cnt[o], 1);
    endfunction

    // Carve the pool into the largest aligned blocks, lowest page first.
    function void carve();
      longint unsigned pages;
      int unsigned idx, rem, o;
      pages = (longint'(pool_b) + PAGE_BYTES - 1) / PAGE_BYTES;
      if (pages > POOL_PAGES) pages = POOL_PAGES;
      npages = int'(pages);
      for (int i = 0; i < POOL_PAGES; i++) begin
        marked[i] = 0;
        tag[i] = UNLISTED;
        nxt[i] = 0;
        prv[i] = 0;
      end
      for (int i = 0; i <= MAX_ORDER; i++) begin
        head[i] = POOL_PAGES;
        cnt[i] = 0;
      end
      free_left = sat_add(0, npages);
      idx = 0;
      rem = npages;
      while (rem > 0) begin
        o = MAX_ORDER;
        while (o > 0 && (((1 << o) > rem) || ((idx & ((1 << o) - 1)) != 0))) o--;
        push(idx, o);
        idx += 1 << o;
        rem -= 1 << o;
      end
      live.delete();
    endfunction

    function void reset_state();
      base = '0;
      pool_b = '0;
      errors = 0;
      checked = 0;
      n_alloc_ok = 0;
      n_free_ok = 0;
      n_error_status = 0;
      carve();
    endfunction

    function void configure(logic [CIDX_W-1:0] idx, logic [ADDR_W-1:0] data);
      if (idx == REG_BASE) base = data;
      else if (idx == REG_POOL) pool_b = data[PB_W-1:0];
      else return;
      carve();
    endfunction

    // Predict the result of one accepted request and queue it.
    function void note_request(logic func, logic [4:0] ord, logic [ADDR_W-1:0] addr);
      alloc_result_t r;
      int unsigned c, blk, cur, bud;
      longint unsigned off;
      r.addr = '0;
      r.status = ST_OK;
      if (ord > MAX_ORDER) begin
        r.status = ST_ORDER_BIG;
      end else if (func == FUNC_ALLOC) begin
        c = ord;
        while (c <= MAX_ORDER && head[c] >= POOL_PAGES) c++;
        if (c > MAX_ORDER) begin
          r.status = ST_NO_MEM;
        end else begin
          blk = head[c];
          unlink(blk);
          while (c > ord) begin
            c--;
            push(blk + (1 << c), c);
          end
          marked[blk] = 1;
          free_left = sat_sub(free_left, 1 << ord);
          r.addr = base + ADDR_W'(blk) * ADDR_W'(PAGE_BYTES);
          live.push_back('{addr: r.addr, order: ord});
        end
      end else if (addr == '0) begin
        r.status = ST_NULL;
      end else if (addr < base || longint'(addr - base) >= longint'(pool_b) ||
                   longint'(addr - base) / PAGE_BYTES >= npages) begin
        r.status = ST_OUT_POOL;
      end else if (addr % PAGE_BYTES != 0) begin
        r.status = ST_MISALIGN;
      end else begin
        off = longint'(addr - base);
        cur = int'(off / PAGE_BYTES);
        c = ord;
        marked[cur] = 0;
        unlink(cur);
        while (c < MAX_ORDER) begin
          bud = cur ^ (1 << c);
          if (bud >= npages || marked[bud] || tag[bud] != c) break;
          unlink(bud);
          if (bud < cur) cur = bud;
          c++;
        end
        push(cur, c);
        free_left = sat_add(free_left, 1 << ord);
        for (int i = live.size() - 1; i >= 0; i--)
          if (live[i].addr == addr) live.delete(i);
      end
      r.page_total = free_left[CNT_W-1:0];
      r.order_blocks = (ord <= MAX_ORDER) ? cnt[ord][CNT_W-1:0] : '0;
      if (r.status == ST_OK && func == FUNC_ALLOC) n_alloc_ok++;
      else if (r.status == ST_OK) n_free_ok++;
      else n_error_status++;
      pending_results.push_back(r);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result addr=%h status=%0d", $time, got.addr,
                 got.status);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.addr !== want.addr) begin
        $display("%0t: alloc_address expected %h actual %h", $time, want.addr, got.addr);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.page_total !== want.page_total) begin
        $display("%0t: free_page_total expected %0d actual %0d", $time,
                 want.page_total, got.page_total);
        errors++;
      end
      if (got.order_blocks !== want.order_blocks) begin
        $display("%0t: order_block_count expected %0d actual %0d", $time,
                 want.order_blocks, got.order_blocks);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bpa_in_if  in_ch();
  bpa_out_if out_ch();
  bpa_cfg_if cfg_ch();

  buddy_page_allocator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  alloc_scoreboard sb;
  int unsigned idle_pct;
  int unsigned stall_pct;
  bit          hold_start;
  int unsigned hold_left;
  int unsigned cycles;

  // Free-running clock, 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Inputs start at known values before the first edge.
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_ALLOC;
    in_ch.block_order = '0;
    in_ch.free_address = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_start = 1'b0;
    hold_left = 0;
    sb = new();
    sb.reset_state();
  end

  // The receiver owns its own stall pattern. A long hold-off, once started,
  // is counted down here so the block fills up behind a waiting result.
  always @(negedge clk) begin
    if (hold_start) begin
      hold_left = LONG_HOLD;
      hold_start = 1'b0;
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Results are sampled at the rising edge, before the block's own updates
  // of that edge take effect.
  always @(posedge clk) begin
    alloc_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.addr = out_ch.alloc_address;
      got.status = out_ch.status;
      got.page_total = out_ch.free_page_total;
      got.order_blocks = out_ch.order_block_count;
      sb.check_result(got);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               sb.pending_results.size());
      $display("buddy_page_allocator_test NOT OK");
      $finish;
    end
  end

  // Offer one request starting at a falling edge; returns at the falling
  // edge after it was accepted, with valid still high.
  task automatic send_request(logic func, logic [4:0] ord, logic [ADDR_W-1:0] addr);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= func;
    in_ch.block_order <= ord;
    in_ch.free_address <= addr;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(func, ord, addr);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted result has been checked.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // A register write is only issued with the block idle. A write of a real
  // register restarts the clear and carve pass, so wait for the request
  // channel to open again before anything else goes out.
  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [ADDR_W-1:0] data);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.configure(idx, data);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_BASE || idx == REG_POOL) begin
      do @(posedge clk); while (!in_ch.ready);
      @(negedge clk);
    end
  endtask

  // One random request. Most are well-formed: allocations of mostly small
  // orders and frees of blocks really held. The rest is noise: random
  // addresses, misaligned or foreign frees, null frees and double frees.
  task automatic random_request();
    int unsigned r, k;
    logic [4:0] ord;
    logic [ADDR_W-1:0] addr;
    r = $urandom_range(0, 99);
    addr = ADDR_W'({$urandom, $urandom});
    if (r < 45) begin
      k = $urandom_range(0, 99);
      ord = (k < 70) ? 5'($urandom_range(0, 3)) :
            (k < 96) ? 5'($urandom_range(4, MAX_ORDER)) : 5'($urandom_range(11, 31));
      send_request(FUNC_ALLOC, ord, addr);
    end else if (r < 85 && sb.live.size() > 0) begin
      k = $urandom_range(0, sb.live.size() - 1);
      send_request(FUNC_FREE, sb.live[k].order, sb.live[k].addr);
    end else begin
      ord = 5'($urandom);
      if ($urandom_range(0, 1)) ord = 5'($urandom_range(0, MAX_ORDER));
      case ($urandom_range(0, 4))
        0: ;
        1: addr = sb.base + ADDR_W'($urandom_range(0, sb.npages)) * ADDR_W'(PAGE_BYTES);
        2: addr = sb.base + ADDR_W'($urandom_range(0, sb.npages)) * ADDR_W'(PAGE_BYTES)
                  + ADDR_W'($urandom_range(1, PAGE_BYTES - 1));
        3: addr = '0;
        default: begin
          // Free a held block with an order that may be wrong.
          if (sb.live.size() > 0) addr = sb.live[$urandom_range(0, sb.live.size() - 1)].addr;
        end
      endcase
      send_request(FUNC_FREE, ord, addr);
    end
  endtask

  // Random traffic in four idling phases: none, sender idle, receiver
  // stalling, both. The long hold-off falls in the first phase.
  task automatic random_phase(int unsigned n_items, bit with_hold);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      if (with_hold && ph == 0) hold_start = 1'b1;
      for (int i = 0; i < n_items / 4; i++) random_request();
      // After the sender-idle phase, pause the sender until the block has nothing left outstanding.
      if (ph == 1) drain();
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // The block clears and carves after reset; wait for it to take requests.
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);

    // Empty pool out of reset: every allocation fails and every free is refused
    // as null, out of pool or order too big.
    send_request(FUNC_ALLOC, 5'd0, '0);
    send_request(FUNC_ALLOC, 5'd31, '0);
    send_request(FUNC_ALLOC, 5'(MAX_ORDER), '0);
    send_request(FUNC_FREE, 5'd0, '0);
    send_request(FUNC_FREE, 5'd0, ADDR_W'(PAGE_BYTES));
    send_request(FUNC_FREE, 5'd11, '1);

    // 38 pages with a ragged last page: blocks of order 5, 2 and 1.
    write_reg(REG_POOL, ADDR_W'(37 * PAGE_BYTES + 5));
    send_request(FUNC_ALLOC, 5'(MAX_ORDER), '0);
    send_request(FUNC_ALLOC, 5'd0, '0);
    send_request(FUNC_ALLOC, 5'd5, '0);
    send_request(FUNC_ALLOC, 5'd2, '0);
    send_request(FUNC_FREE, 5'd5, '0);
    send_request(FUNC_FREE, 5'd5, ADDR_W'(PAGE_BYTES + 1));
    send_request(FUNC_FREE, 5'd0, ADDR_W'(38 * PAGE_BYTES));
    send_request(FUNC_FREE, 5'd0, ADDR_W'(37 * PAGE_BYTES));
    send_request(FUNC_FREE, 5'd0, ADDR_W'(37 * PAGE_BYTES));
    send_request(FUNC_FREE, 5'd5, ADDR_W'(32 * PAGE_BYTES));
    send_request(FUNC_FREE, 5'd12, ADDR_W'(32 * PAGE_BYTES));
    send_request(FUNC_FREE, 5'(MAX_ORDER), ADDR_W'(16 * PAGE_BYTES));
    send_request(FUNC_FREE, 5'd0, 48'hFFFF_FFFF_F000);
    // An unknown register index changes nothing.
    write_reg(REG_UNUSED, 48'h0000_DEAD_BEEF);
    send_request(FUNC_ALLOC, 5'd1, '0);
    random_phase(500, 1'b1);

    // Base at the top of the address space: block addresses wrap.
    write_reg(REG_BASE, '1);
    send_request(FUNC_ALLOC, 5'd3, '0);
    send_request(FUNC_FREE, 5'd0, '1);
    random_phase(240, 1'b0);

    // Largest pool, exactly at the page limit, at an ordinary base.
    write_reg(REG_BASE, 48'h0012_3450_0000);
    write_reg(REG_POOL, ADDR_W'(268435456));
    random_phase(900, 1'b1);

    // Single page pool at a low base.
    write_reg(REG_POOL, ADDR_W'(1));
    write_reg(REG_BASE, ADDR_W'(PAGE_BYTES));
    random_phase(240, 1'b0);

    drain();
    repeat (200) @(posedge clk);
    if (sb.pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time,
               sb.pending_results.size());
      sb.errors++;
    end
    $display("Checked %0d results: %0d allocations, %0d frees, %0d error statuses,",
             sb.checked, sb.n_alloc_ok, sb.n_free_ok, sb.n_error_status);
    $display("over empty, ragged, wrapped, full and single-page pools.");
    if (sb.errors == 0) begin
      $display("buddy_page_allocator_test OK");
    end else begin
      $display("buddy_page_allocator_test NOT OK");
    end
    $finish;
  end

endmodule

@@ buddy_page_allocator.f @@
rtl/core/bpa_pkg.sv
rtl/core/bpa_if.sv
rtl/core/buddy_page_allocator.sv
tb/buddy_page_allocator_test.sv
